/* hw/rtl/adts_frame_walker_unit_assert.svh */
// Assertion helpers used by the walker back end.
// Both forms check on the rising clock edge and are disabled during reset.
`ifndef ADTS_FRAME_WALKER_UNIT_ASSERT_SVH
`define ADTS_FRAME_WALKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define AFW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adts frame walker check failed");
// The consequent must hold in the cycle after the antecedent.
`define AFW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adts frame walker check failed");
`else
`define AFW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AFW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/afw_pkg.sv */
`default_nettype none
package afw_pkg;

    localparam int HDR_LEN     = 6;
    localparam int HDR_STORED  = HDR_LEN - 1;
    localparam int MIN_LEN     = 7;
    localparam int LEN_BITS    = 13;
    localparam int TOTAL_BITS  = 40;
    localparam int RATE_BITS   = 17;
    localparam int FC_OUT_BITS = 24;
    localparam int DUR_BITS    = 22;
    localparam int KBPS_BITS   = 13;
    localparam int DUR_SHIFT   = 10;
    localparam int KBPS_SHIFT  = 10;
    localparam int KBPS_SCALE  = 1000;
    localparam int BITS_SHIFT  = 3;
    localparam int NUM_BITS    = TOTAL_BITS + RATE_BITS + BITS_SHIFT;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_MASK = 8'hF6;
    localparam logic [7:0] SYNC_VAL  = 8'hF0;

    localparam logic [FC_OUT_BITS-1:0] FC_OUT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX  = '1;
    localparam logic [DUR_BITS-1:0]    DUR_MAX    = '1;
    localparam logic [KBPS_BITS-1:0]   KBPS_MAX   = '1;

    typedef struct packed {
        logic [FC_OUT_BITS-1:0] frame_count;
        logic [TOTAL_BITS-1:0]  total_frame_bytes;
        logic [RATE_BITS-1:0]   sample_rate_hz;
        logic [DUR_BITS-1:0]    duration_seconds;
        logic [KBPS_BITS-1:0]   bitrate_kbps;
        logic                   sync_lost;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [RATE_BITS-1:0] rate_of(input logic [3:0] idx);
        logic [RATE_BITS-1:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = '0;
        endcase
        return hz;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/afw_if.sv */
`default_nettype none
interface afw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, data_byte, last_byte, input ready);
    modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface afw_sum_if;
    import afw_pkg::*;
    logic    valid;
    logic    ready;
    t_result result;

    modport source(output valid, result, input ready);
    modport sink(input valid, result, output ready);
endinterface
`default_nettype wire

/* hw/rtl/afw_front.sv */
`default_nettype none
module afw_front #(
    parameter int FCB   = 24,
    parameter int JOB_W = FCB + 46
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    afw_byte_if.sink                i_byte,
    input  wire afw_pkg::t_q_status i_q_status,
    output logic                    o_push,
    output logic [JOB_W-1:0]        o_job
);
    import afw_pkg::*;

    typedef enum logic [1:0] {PH_COLLECT, PH_SKIP, PH_STOP} t_phase;

    t_phase                r_phase, n_phase;
    logic [2:0]            r_idx, n_idx;
    logic [7:0]            r_hdr [HDR_STORED];
    logic [LEN_BITS-1:0]   r_skip, n_skip;
    logic [FCB-1:0]        r_fc, n_fc;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic [3:0]            r_ridx, n_ridx;
    logic                  r_latched, n_latched;

    logic                  w_accept;
    logic                  w_sync_ok;
    logic [LEN_BITS-1:0]   w_len;
    logic [TOTAL_BITS:0]   w_sum;

    assign i_byte.ready = !i_q_status.full;
    assign w_accept     = i_byte.valid && i_byte.ready;

    assign w_sync_ok = (r_hdr[0] == SYNC_BYTE) && ((r_hdr[1] & SYNC_MASK) == SYNC_VAL);
    assign w_len     = {r_hdr[3][1:0], r_hdr[4], i_byte.data_byte[7:5]};
    assign w_sum     = {1'b0, r_total} + (TOTAL_BITS + 1)'(w_len);

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_skip    = r_skip;
        n_fc      = r_fc;
        n_total   = r_total;
        n_ridx    = r_ridx;
        n_latched = r_latched;
        o_push    = 1'b0;
        o_job     = '0;
        if (w_accept) begin
            case (r_phase)
                PH_COLLECT: begin
                    if (r_idx == 3'(HDR_STORED)) begin
                        n_idx = '0;
                        if (!w_sync_ok) begin
                            n_phase = PH_STOP;
                        end else begin
                            if (!r_latched) begin
                                n_ridx    = r_hdr[2][5:2];
                                n_latched = 1'b1;
                            end
                            if (w_len < LEN_BITS'(MIN_LEN)) begin
                                n_phase = PH_STOP;
                            end else begin
                                if (r_fc != '1) begin
                                    n_fc = r_fc + 1'b1;
                                end
                                n_total = w_sum[TOTAL_BITS] ? TOTAL_MAX : w_sum[TOTAL_BITS-1:0];
                                n_skip  = w_len - LEN_BITS'(HDR_LEN);
                                n_phase = PH_SKIP;
                            end
                        end
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - LEN_BITS'(r_skip != '0);
                    if (n_skip == '0) begin
                        n_phase = PH_COLLECT;
                        n_idx   = '0;
                    end
                end
                default: begin
                end
            endcase
            if (i_byte.last_byte) begin
                // The summary reflects this byte's update; then a new stream begins.
                o_push    = 1'b1;
                o_job     = {n_phase == PH_STOP, n_latched, n_ridx, n_total, n_fc};
                n_phase   = PH_COLLECT;
                n_idx     = '0;
                n_skip    = '0;
                n_fc      = '0;
                n_total   = '0;
                n_ridx    = '0;
                n_latched = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_COLLECT;
            r_idx     <= '0;
            r_skip    <= '0;
            r_fc      <= '0;
            r_total   <= '0;
            r_ridx    <= '0;
            r_latched <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_skip    <= n_skip;
            r_fc      <= n_fc;
            r_total   <= n_total;
            r_ridx    <= n_ridx;
            r_latched <= n_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_phase == PH_COLLECT && r_idx != 3'(HDR_STORED)) begin
            r_hdr[r_idx] <= i_byte.data_byte;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/afw_fifo.sv */
`default_nettype none
module afw_fifo #(
    parameter int WIDTH = 70,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output afw_pkg::t_q_status    o_status
);
    import afw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/afw_div.sv */
`default_nettype none
module afw_div #(
    parameter int NW = 60,
    parameter int DW = 44
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic [NW-1:0]      o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // One quotient bit per cycle, restoring form.
    assign w_sh   = {r_rem, r_q[NW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_diff = w_sh - {1'b0, r_den};

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/afw_back.sv */
`default_nettype none
`include "adts_frame_walker_unit_assert.svh"
module afw_back #(
    parameter int FCB   = 24,
    parameter int JOB_W = FCB + 46
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire afw_pkg::t_q_status i_q_status,
    input  wire logic [JOB_W-1:0]   i_job,
    output logic                    o_pop,
    afw_sum_if.source               o_sum
);
    import afw_pkg::*;

    localparam int DENW = FCB + 10;
    localparam int DW   = DENW + KBPS_SHIFT;
    localparam int PW   = TOTAL_BITS + RATE_BITS;
    localparam int MCW  = $clog2(RATE_BITS + 1);
    localparam int FCW  = (FCB > FC_OUT_BITS) ? FCB : FC_OUT_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DUR, ST_DUR_WAIT, ST_KBPS_WAIT, ST_DONE
    } t_state;

    t_state                r_state;
    logic [FCB-1:0]        r_fc;
    logic [TOTAL_BITS-1:0] r_total;
    logic [RATE_BITS-1:0]  r_rate;
    logic                  r_stop;
    logic [PW-1:0]         r_mul_a;
    logic [RATE_BITS-1:0]  r_mul_b;
    logic [PW-1:0]         r_acc;
    logic [MCW-1:0]        r_mcnt;
    logic [DENW-1:0]       r_den;
    logic [DUR_BITS-1:0]   r_dur;
    logic [KBPS_BITS-1:0]  r_kbps;
    logic                  r_div_start;
    logic [NUM_BITS-1:0]   r_div_num;
    logic [DW-1:0]         r_div_den;
    logic                  r_out_valid;
    t_result               r_out;

    logic [FCB-1:0]        w_job_fc;
    logic [TOTAL_BITS-1:0] w_job_total;
    logic [3:0]            w_job_ridx;
    logic                  w_job_latched;
    logic                  w_job_stop;
    logic [RATE_BITS-1:0]  w_job_rate;
    logic                  w_load;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [NUM_BITS-1:0]   w_quot;
    logic [FCW-1:0]        w_fc_ext;
    logic [FC_OUT_BITS-1:0] w_fc_out;

    assign w_job_fc      = i_job[FCB-1:0];
    assign w_job_total   = i_job[FCB +: TOTAL_BITS];
    assign w_job_ridx    = i_job[FCB + TOTAL_BITS +: 4];
    assign w_job_latched = i_job[FCB + TOTAL_BITS + 4];
    assign w_job_stop    = i_job[FCB + TOTAL_BITS + 5];
    assign w_job_rate    = w_job_latched ? rate_of(w_job_ridx) : '0;

    assign o_pop  = (r_state == ST_IDLE) && !i_q_status.empty;
    assign w_load = (r_state == ST_DONE) && (!r_out_valid || o_sum.ready);

    assign w_fc_ext = FCW'(r_fc);
    assign w_fc_out = (w_fc_ext > FCW'(FC_OUT_MAX)) ? FC_OUT_MAX : w_fc_ext[FC_OUT_BITS-1:0];

    assign o_sum.valid  = r_out_valid;
    assign o_sum.result = r_out;

    afw_div #(
        .NW (NUM_BITS),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (o_sum.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_fc    <= w_job_fc;
                        r_total <= w_job_total;
                        r_rate  <= w_job_rate;
                        r_stop  <= w_job_stop;
                        r_mul_a <= PW'(w_job_total);
                        r_mul_b <= w_job_rate;
                        r_acc   <= '0;
                        r_mcnt  <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Shift-and-add product of total bytes and rate, one rate bit a cycle.
                    if (r_mul_b[0]) begin
                        r_acc <= r_acc + r_mul_a;
                    end
                    r_mul_a <= r_mul_a << 1;
                    r_mul_b <= r_mul_b >> 1;
                    r_den   <= DENW'(r_fc) * DENW'(KBPS_SCALE);
                    r_mcnt  <= r_mcnt + 1'b1;
                    if (r_mcnt == MCW'(RATE_BITS - 1)) begin
                        r_state <= ST_DUR;
                    end
                end
                ST_DUR: begin
                    if (r_rate == '0) begin
                        r_dur   <= '0;
                        r_kbps  <= '0;
                        r_state <= ST_DONE;
                    end else begin
                        r_div_num   <= NUM_BITS'({r_fc, DUR_SHIFT'(0)});
                        r_div_den   <= DW'(r_rate);
                        r_div_start <= 1'b1;
                        r_state     <= ST_DUR_WAIT;
                    end
                end
                ST_DUR_WAIT: begin
                    if (w_div_done) begin
                        r_dur <= (w_quot > NUM_BITS'(DUR_MAX)) ? DUR_MAX : w_quot[DUR_BITS-1:0];
                        if (r_fc == '0) begin
                            r_kbps  <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_div_num   <= {r_acc, BITS_SHIFT'(0)};
                            r_div_den   <= {r_den, KBPS_SHIFT'(0)};
                            r_div_start <= 1'b1;
                            r_state     <= ST_KBPS_WAIT;
                        end
                    end
                end
                ST_KBPS_WAIT: begin
                    if (w_div_done) begin
                        r_kbps  <= (w_quot > NUM_BITS'(KBPS_MAX)) ? KBPS_MAX
                                                                  : w_quot[KBPS_BITS-1:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{
                            frame_count:       w_fc_out,
                            total_frame_bytes: r_total,
                            sample_rate_hz:    r_rate,
                            duration_seconds:  r_dur,
                            bitrate_kbps:      r_kbps,
                            sync_lost:         r_stop
                        };
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `AFW_ASSERT_IMP(a_start_not_busy, i_clk, i_rst_n, r_div_start, !w_div_busy)
    `AFW_ASSERT_NXT(a_pop_leaves_idle, i_clk, i_rst_n, o_pop, r_state == ST_MUL)
    `AFW_ASSERT_NXT(a_zero_rate_zero, i_clk, i_rst_n, w_load && r_rate == '0,
                    r_out.duration_seconds == '0 && r_out.bitrate_kbps == '0)

endmodule
`default_nettype wire

/* hw/rtl/adts_frame_walker_unit.sv */
`default_nettype none
// Channel   Direction  Payload                                    Accepted when
// i_byte    in         data_byte, last_byte                       valid && ready
// o_sum     out        result: counts, rate, duration, bitrate    valid && ready
//
// The walker takes one byte word per cycle. Ready drops only while both queue entries
// hold jobs, which needs two more stream ends to arrive while the back end still works on
// an earlier one.
// In the back end each summary goes through the serial rate multiply and then
// the shared one-bit-a-cycle divider.
// Reset is synchronous and active low; it clears the walk, queue and sequencer.
// A summary word holds in the output register until o_sum.ready takes it, while
// the walker keeps accepting bytes of the next stream.
module adts_frame_walker_unit #(
    parameter int FRAME_COUNT_BITS = 24,
    parameter int QUEUE_DEPTH      = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    afw_byte_if.sink  i_byte,
    afw_sum_if.source o_sum
);
    import afw_pkg::*;

    // A queued summary job carries the raw walk result: frame count, byte total,
    // rate index with its latch flag, and the sync-lost flag.
    localparam int JOB_W = FRAME_COUNT_BITS + TOTAL_BITS + 6;

    logic             w_push;
    logic             w_pop;
    logic [JOB_W-1:0] w_job_in;
    logic [JOB_W-1:0] w_job_out;
    t_q_status        w_q_status;

    // Front end: header gather, sync and length checks, frame counting, body skip.
    afw_front #(
        .FCB   (FRAME_COUNT_BITS),
        .JOB_W (JOB_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    // Short queue of finished stream jobs between the two halves.
    afw_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_job_in),
        .i_pop    (w_pop),
        .o_data   (w_job_out),
        .o_status (w_q_status)
    );

    // Back end: rate lookup, duration and bitrate divisions, output register.
    afw_back #(
        .FCB   (FRAME_COUNT_BITS),
        .JOB_W (JOB_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .o_sum      (o_sum)
    );

endmodule
`default_nettype wire

/* verif/adts_summary_checker.sv */
module adts_summary_checker #(
    parameter int FRAME_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    afw_byte_if       i_byte,
    afw_sum_if        o_sum,
    output int        o_mismatches,
    output int        o_summaries_due,
    output int        o_summaries_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import afw_pkg::*;

    typedef enum logic [1:0] {
        WALK_HEADER  = 2'd0,
        WALK_BODY    = 2'd1,
        WALK_STOPPED = 2'd2
    } t_walk_phase;

    localparam logic [63:0] SAMPLES_PER_FRAME = 64'd1024;
    localparam logic [63:0] KBPS_DIVISOR      = 64'd1024000;

    logic [RATE_BITS-1:0]  hz_table [16];
    t_walk_phase           phase_q;
    logic [2:0]            hdr_fill;
    logic [7:0]            hdr [HDR_LEN];
    logic [LEN_BITS-1:0]   skip_left;
    logic [FRAME_BITS-1:0] frames;
    logic [TOTAL_BITS-1:0] total;
    logic [3:0]            rate_idx;
    logic                  rate_held;
    logic                  walk_stopped;
    t_result               summary_due_q [$];
    int                    mismatches;
    int                    due_n;
    int                    seen_n;

    assign o_mismatches     = mismatches;
    assign o_summaries_due  = due_n;
    assign o_summaries_seen = seen_n;

    initial begin
        hz_table = '{17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
                     17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
                     17'd7350, 17'd0, 17'd0, 17'd0};
    end

    task automatic clear_walk();
        phase_q      = WALK_HEADER;
        hdr_fill     = '0;
        foreach (hdr[k]) hdr[k] = '0;
        skip_left    = '0;
        frames       = '0;
        total        = '0;
        rate_idx     = '0;
        rate_held    = 1'b0;
        walk_stopped = 1'b0;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Outputs are checked before the byte of the same edge is walked; a summary
    // can never leave in the cycle its last byte enters.
    always @(posedge i_clk) begin : predict_and_compare
        logic [LEN_BITS-1:0]  len;
        logic [RATE_BITS-1:0] hz;
        logic [63:0]          fc_wide;
        logic [63:0]          dur;
        logic [63:0]          kbps;
        t_result              want;
        t_result              got;
        if (!i_rst_n) begin
            clear_walk();
            summary_due_q.delete();
            due_n = 0;
        end else begin
            if (o_sum.valid && o_sum.ready) begin
                got = o_sum.result;
                if (summary_due_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: summary word with none expected, expected nothing, got %h",
                             $time, got);
                end else begin
                    want = summary_due_q.pop_front();
                    due_n--;
                    seen_n++;
                    check_field("frame_count", want.frame_count, got.frame_count);
                    check_field("total_frame_bytes", want.total_frame_bytes,
                                got.total_frame_bytes);
                    check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
                    check_field("duration_seconds", want.duration_seconds,
                                got.duration_seconds);
                    check_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
                    check_field("sync_lost", want.sync_lost, got.sync_lost);
                end
            end
            if (i_byte.valid && i_byte.ready) begin
                case (phase_q)
                    WALK_HEADER: begin
                        if (hdr_fill > HDR_STORED) hdr_fill = '0;
                        hdr[hdr_fill] = i_byte.data_byte;
                        hdr_fill++;
                        if (hdr_fill == HDR_LEN) begin
                            hdr_fill = '0;
                            len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
                            if (hdr[0] != SYNC_BYTE || (hdr[1] & SYNC_MASK) != SYNC_VAL) begin
                                walk_stopped = 1'b1;
                                phase_q      = WALK_STOPPED;
                            end else begin
                                if (!rate_held) begin
                                    rate_idx  = hdr[2][5:2];
                                    rate_held = 1'b1;
                                end
                                if (len < MIN_LEN) begin
                                    walk_stopped = 1'b1;
                                    phase_q      = WALK_STOPPED;
                                end else begin
                                    if (frames != {FRAME_BITS{1'b1}}) frames++;
                                    if (total > TOTAL_MAX - TOTAL_BITS'(len)) total = TOTAL_MAX;
                                    else total = total + TOTAL_BITS'(len);
                                    skip_left = len - LEN_BITS'(HDR_LEN);
                                    phase_q   = WALK_BODY;
                                end
                            end
                        end
                    end
                    WALK_BODY: begin
                        if (skip_left != '0) skip_left--;
                        if (skip_left == '0) begin
                            phase_q  = WALK_HEADER;
                            hdr_fill = '0;
                        end
                    end
                    default: begin
                    end
                endcase
                if (i_byte.last_byte) begin
                    hz      = rate_held ? hz_table[rate_idx] : '0;
                    fc_wide = 64'(frames);
                    dur     = '0;
                    kbps    = '0;
                    if (hz != '0) begin
                        dur = (fc_wide * SAMPLES_PER_FRAME) / 64'(hz);
                        if (dur > 64'(DUR_MAX)) dur = 64'(DUR_MAX);
                        if (fc_wide != '0) begin
                            kbps = (64'(total) * 64'd8 * 64'(hz)) / (KBPS_DIVISOR * fc_wide);
                            if (kbps > 64'(KBPS_MAX)) kbps = 64'(KBPS_MAX);
                        end
                    end
                    want.frame_count = (fc_wide > 64'(FC_OUT_MAX)) ? FC_OUT_MAX
                                                                    : fc_wide[FC_OUT_BITS-1:0];
                    want.total_frame_bytes = total;
                    want.sample_rate_hz    = hz;
                    want.duration_seconds  = dur[DUR_BITS-1:0];
                    want.bitrate_kbps      = kbps[KBPS_BITS-1:0];
                    want.sync_lost         = walk_stopped;
                    summary_due_q.push_back(want);
                    due_n++;
                    clear_walk();
                end
            end
        end
    end

endmodule

/* verif/tb_adts_frame_walker_unit.sv */
module tb_adts_frame_walker_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import afw_pkg::*;

    // Ways a generated header can be spoiled.
    typedef enum int {
        HDR_CLEAN,
        HDR_BAD_LEAD,
        HDR_BAD_ID
    } t_hdr_flaw;

    // Longest run without any word moving before the run is declared hung. The
    // slowest legal gap is the receiver hold-off below plus one back end pass,
    // so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int HOLD_CYCLES       = 1500;
    localparam int HOLD_STREAMS      = 8;
    localparam int RANDOM_BYTES_EACH = 390;
    localparam int DRAIN_CYCLES      = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    afw_byte_if byte_ch ();
    afw_sum_if  sum_ch ();

    int         mismatches;
    int         summaries_due;
    int         summaries_seen;
    logic       byte_taken;
    int         src_idle_pct;
    int         sink_idle_pct;
    int         hold_asks;
    int         hold_seen;
    int         hold_left;
    int         idle_cycles;
    int         bytes_sent;
    int         streams_sent;
    logic [7:0] stream_q [$];

    adts_frame_walker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_sum   (sum_ch)
    );

    adts_summary_checker walk_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte           (byte_ch),
        .o_sum            (sum_ch),
        .o_mismatches     (mismatches),
        .o_summaries_due  (summaries_due),
        .o_summaries_seen (summaries_seen)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The handshake flag is registered with a nonblocking assignment, so the
    // driver, which only looks at it on falling edges, always sees the outcome
    // of the rising edge just passed. The watchdog shares the same edge.
    always @(posedge i_clk) begin
        byte_taken <= i_rst_n && byte_ch.valid && byte_ch.ready;
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (sum_ch.valid && sum_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved on either channel for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver side. It stalls at random according to sink_idle_pct, and when
    // the stimulus raises hold_asks it keeps ready low until hold_left, loaded
    // from HOLD_CYCLES and counted down here, reaches zero, so the summary queue
    // fills and the block pushes back on its byte input. hold_asks only changes on
    // a rising edge, so the check below on the falling edge is free of ordering races.
    initial begin : receiver
        sum_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                sum_ch.ready <= 1'b0;
            end else begin
                sum_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    function automatic int pick_len();
        return ($urandom_range(9) == 0) ? MIN_LEN : int'($urandom_range(20, MIN_LEN));
    endfunction

    // Mostly real table entries; now and then one of the reserved indices.
    function automatic int pick_index();
        return ($urandom_range(7) == 0) ? int'($urandom_range(15, 13)) : int'($urandom_range(12));
    endfunction

    // Appends one six-byte header. All bits outside sync, rate index and
    // length are random so that every bit position is exercised.
    task automatic push_header(input int len, input int idx, input t_hdr_flaw flaw);
        logic [LEN_BITS-1:0] l13;
        logic [3:0]          r4;
        logic [7:0]          h [HDR_LEN];
        l13  = LEN_BITS'(len);
        r4   = 4'(idx);
        h[0] = SYNC_BYTE;
        h[1] = SYNC_VAL | (8'($urandom) & ~SYNC_MASK);
        h[2] = (8'($urandom) & 8'hC3) | {2'b00, r4, 2'b00};
        h[3] = {6'($urandom), l13[12:11]};
        h[4] = l13[10:3];
        h[5] = {l13[2:0], 5'($urandom)};
        if (flaw == HDR_BAD_LEAD) begin
            while (h[0] == SYNC_BYTE) h[0] = 8'($urandom);
        end
        if (flaw == HDR_BAD_ID) begin
            while ((h[1] & SYNC_MASK) == SYNC_VAL) h[1] = 8'($urandom);
        end
        foreach (h[k]) stream_q.push_back(h[k]);
    endtask

    task automatic push_body(input int n);
        repeat (n) stream_q.push_back(8'($urandom));
    endtask

    // Sends the queued stream one word at a time, marking the final word as
    // the last byte. Valid stays high from one word to the next unless the
    // sender decides to idle, so back-to-back words get no gap.
    task automatic send_stream();
        int n;
        n = stream_q.size();
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99) < src_idle_pct) begin
                byte_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            byte_ch.valid     <= 1'b1;
            byte_ch.data_byte <= stream_q[i];
            byte_ch.last_byte <= (i == n - 1);
            @(negedge i_clk);
            while (!byte_taken) @(negedge i_clk);
            bytes_sent++;
        end
        stream_q.delete();
        streams_sent++;
    endtask

    // Sender pause: drop valid and wait until every summary has been seen.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (summaries_due != 0) @(negedge i_clk);
    endtask

    // One random phase. Most streams are well formed so that the walk gets
    // through several frames; they end exactly on a frame boundary, inside a
    // header, or inside a body whose length may be as large as the field
    // allows. The rest break the walk with a bad sync or a short length, or
    // are plain noise.
    task automatic run_random(input int src_pct, input int sink_pct, input int n_bytes);
        int stop_at;
        int kind;
        int len;
        int cut;
        sink_idle_pct = sink_pct;
        stop_at       = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            // One stream in eight goes out with the sender never idling.
            src_idle_pct = ($urandom_range(7) == 0) ? 0 : src_pct;
            kind         = $urandom_range(99);
            if (kind < 70) begin
                repeat ($urandom_range(3, 1)) begin
                    len = pick_len();
                    push_header(len, pick_index(), HDR_CLEAN);
                    push_body(len - HDR_LEN);
                end
                case ($urandom_range(3))
                    1: begin
                        // Cut short inside the next header.
                        push_header(pick_len(), pick_index(), HDR_CLEAN);
                        repeat ($urandom_range(5, 1)) stream_q.delete(stream_q.size() - 1);
                    end
                    2: begin
                        // A frame of any length whose body is cut short.
                        len = $urandom_range(8191, MIN_LEN);
                        push_header(len, pick_index(), HDR_CLEAN);
                        cut = (len - MIN_LEN < 20) ? len - MIN_LEN : 20;
                        push_body($urandom_range(cut, 0));
                    end
                    default: begin
                    end
                endcase
            end else if (kind < 85) begin
                repeat ($urandom_range(2, 0)) begin
                    len = pick_len();
                    push_header(len, pick_index(), HDR_CLEAN);
                    push_body(len - HDR_LEN);
                end
                case ($urandom_range(2))
                    0:       push_header(pick_len(), pick_index(), HDR_BAD_LEAD);
                    1:       push_header(pick_len(), pick_index(), HDR_BAD_ID);
                    default: push_header($urandom_range(MIN_LEN - 1, 0), pick_index(), HDR_CLEAN);
                endcase
                // Bytes after the stop are ignored by the walk.
                push_body($urandom_range(10, 0));
            end else begin
                push_body($urandom_range(12, 1));
            end
            send_stream();
        end
        wait_drained();
    endtask

    initial begin : stimulus
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        i_rst_n           <= 1'b0;
        src_idle_pct  = 22;
        sink_idle_pct = 73;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed streams. A lone last byte ends the walk inside the first
        // header, so nothing is counted and sync is not reported lost.
        stream_q.push_back(SYNC_BYTE);
        send_stream();
        // Largest length with the slowest rate; the header completes on the
        // last byte, so the frame counts although its body never arrives.
        push_header(8191, 12, HDR_CLEAN);
        send_stream();
        // Bad sync word, followed by a byte the stopped walk must ignore.
        push_header(MIN_LEN, 0, HDR_BAD_LEAD);
        stream_q.push_back(8'h00);
        send_stream();
        // Length one below the minimum, with a reserved rate index latched.
        push_header(MIN_LEN - 1, 13, HDR_CLEAN);
        send_stream();
        // Shortest legal frame at the fastest rate, ending on its body byte.
        push_header(MIN_LEN, 0, HDR_CLEAN);
        stream_q.push_back(8'h00);
        send_stream();
        wait_drained();

        // Long receiver hold-off while the sender keeps offering short
        // streams, so summaries back up and the byte input stalls.
        src_idle_pct = 0;
        @(posedge i_clk);
        hold_asks++;
        @(negedge i_clk);
        repeat (HOLD_STREAMS) begin
            push_header(MIN_LEN, pick_index(), HDR_CLEAN);
            push_body(1);
            send_stream();
        end
        wait_drained();

        // Random phases under three idle mixes.
        run_random(22, 73, RANDOM_BYTES_EACH);
        run_random(73, 22, RANDOM_BYTES_EACH);
        run_random(0, 0, RANDOM_BYTES_EACH);

        // Give the back end time to show any summary it should not make.
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Walked %0d byte words in %0d streams; %0d summary words compared, %0d bad.",
                 bytes_sent, streams_sent, summaries_seen, mismatches);
        $display("Idle mixes 22/73, 73/22 and 0/0, plus a %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && summaries_due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
